// ----- hdl/adu_pkg.sv -----
// Shared types, mode codes and exponential tables for the activation derivative unit.
`timescale 1ns / 1ps
`default_nettype none
package adu_pkg;

  typedef enum logic [1:0] {
    MODE_SIGMOID = 2'd0,
    MODE_RELU    = 2'd1,
    MODE_TANH    = 2'd2,
    MODE_LINEAR  = 2'd3
  } act_mode_t;

  localparam logic [15:0] Q_ONE      = 16'd4096;
  localparam int          EXP_STEPS  = 12;
  localparam int          QUOT_BITS  = 13;

  typedef struct packed {
    logic        valid;
    logic        is_tanh;
    logic [15:0] alt;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [16:0] t;
    logic [11:0] f;
  } exp_t;

  typedef struct packed {
    ctl_t        ctl;
    logic [47:0] rem;
    logic [34:0] den;
    logic [12:0] q;
  } quot_t;

  // e^-n in Q1.16
  function automatic logic [16:0] exp_whole(input logic [4:0] n);
    logic [16:0] r;
    unique case (n)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd24109;
      5'd2:    r = 17'd8869;
      5'd3:    r = 17'd3263;
      5'd4:    r = 17'd1200;
      5'd5:    r = 17'd442;
      5'd6:    r = 17'd162;
      5'd7:    r = 17'd60;
      5'd8:    r = 17'd22;
      5'd9:    r = 17'd8;
      5'd10:   r = 17'd3;
      5'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // e^-(2^(k-12)) in Q0.16
  function automatic logic [15:0] exp_part(input int k);
    logic [15:0] r;
    unique case (k)
      0:       r = 16'd65520;
      1:       r = 16'd65504;
      2:       r = 16'd65472;
      3:       r = 16'd65408;
      4:       r = 16'd65280;
      5:       r = 16'd65026;
      6:       r = 16'd64520;
      7:       r = 16'd63520;
      8:       r = 16'd61565;
      9:       r = 16'd57835;
      10:      r = 16'd51039;
      default: r = 16'd39750;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/activation_derivative_unit_core.sv -----
// Activation derivative unit: sigmoid, relu, tanh (sech^2) and linear derivatives in Q4.12.
// 29 register stages; 12 exponential multiply stages and 13 divide stages set the depth.
// Throughput: one item per cycle while the output does not stall.
// The whole pipeline advances together; an output stall on a valid result holds every stage and the input.
// Synchronous reset clears all valid bits and sets act_mode to sigmoid.
`timescale 1ns / 1ps
`default_nettype none
module activation_derivative_unit_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] x_value,
  input  wire logic signed [15:0] y_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      deriv_value
);

  adu_pkg::act_mode_t act_mode;
  logic adv;

  // stage 1: input capture
  logic               s1_valid;
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_y;
  adu_pkg::act_mode_t s1_mode;

  // stage 2: exp seed, sigmoid product, fixed results
  logic               s2_valid;
  adu_pkg::act_mode_t s2_mode;
  logic [16:0]        s2_t;
  logic [11:0]        s2_f;
  logic signed [32:0] s2_prod;
  logic [15:0]        s2_alt;

  logic [15:0]        x_abs;
  logic [16:0]        a_val;
  logic signed [16:0] y_comp;
  logic [15:0]        alt_fixed;

  logic signed [33:0] sig_sum;
  logic signed [33:0] sig_sh;
  logic [15:0]        sig_res;

  adu_pkg::exp_t  exp_pipe [0:adu_pkg::EXP_STEPS];
  adu_pkg::quot_t div_pipe [0:adu_pkg::QUOT_BITS];

  // denominator stage
  adu_pkg::ctl_t den_ctl;
  logic [16:0]   den_t;
  logic [34:0]   den_val;
  logic [17:0]   s_sum;
  logic [35:0]   s_sq;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_mode <= adu_pkg::MODE_SIGMOID;
    end else if (cfg_wr_en) begin
      act_mode <= adu_pkg::act_mode_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s1_x <= x_value;
      s1_y <= y_value;
      s1_mode <= act_mode;
    end
  end

  always_comb begin
    x_abs = s1_x[15] ? 16'(-s1_x) : 16'(s1_x);
    a_val = {x_abs, 1'b0};
    y_comp = 17'sd4096 - 17'(s1_y);
    unique case (s1_mode)
      adu_pkg::MODE_RELU:   alt_fixed = (!s1_x[15] && s1_x != 16'sd0) ? adu_pkg::Q_ONE : 16'd0;
      adu_pkg::MODE_LINEAR: alt_fixed = adu_pkg::Q_ONE;
      default:              alt_fixed = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s2_mode <= s1_mode;
      s2_t <= adu_pkg::exp_whole(a_val[16:12]);
      s2_f <= a_val[11:0];
      s2_prod <= 33'(s1_y) * 33'(y_comp);
      s2_alt <= alt_fixed;
    end
  end

  // sigmoid: round half up, floor shift, saturate
  always_comb begin
    sig_sum = 34'(s2_prod) + 34'sd2048;
    sig_sh = sig_sum >>> 12;
    if (sig_sh > 34'sd32767) begin
      sig_res = 16'h7fff;
    end else if (sig_sh < -34'sd32768) begin
      sig_res = 16'h8000;
    end else begin
      sig_res = sig_sh[15:0];
    end
    exp_pipe[0].ctl.valid = s2_valid;
    exp_pipe[0].ctl.is_tanh = (s2_mode == adu_pkg::MODE_TANH);
    exp_pipe[0].ctl.alt = (s2_mode == adu_pkg::MODE_SIGMOID) ? sig_res : s2_alt;
    exp_pipe[0].t = s2_t;
    exp_pipe[0].f = s2_f;
  end

  for (genvar k = 0; k < adu_pkg::EXP_STEPS; k++) begin : g_exp
    adu_exp_step u_exp (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .d        (exp_pipe[k]),
      .e_coef   (adu_pkg::exp_part(k)),
      .use_step (exp_pipe[k].f[k]),
      .q        (exp_pipe[k+1])
    );
  end

  always_comb begin
    s_sum = 18'(exp_pipe[adu_pkg::EXP_STEPS].t) + 18'd65536;
    s_sq = 36'(s_sum) * 36'(s_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      den_ctl.valid <= 1'b0;
    end else if (adv) begin
      den_ctl <= exp_pipe[adu_pkg::EXP_STEPS].ctl;
      den_t <= exp_pipe[adu_pkg::EXP_STEPS].t;
      den_val <= s_sq[34:0];
    end
  end

  // numerator: t * 2^30 plus half the divisor for rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      div_pipe[0].ctl.valid <= 1'b0;
    end else if (adv) begin
      div_pipe[0].ctl <= den_ctl;
      div_pipe[0].rem <= (48'(den_t) << 30) + 48'(den_val[34:1]);
      div_pipe[0].den <= den_val;
      div_pipe[0].q <= '0;
    end
  end

  for (genvar i = 0; i < adu_pkg::QUOT_BITS; i++) begin : g_div
    adu_div_step u_div (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .d      (div_pipe[i]),
      .den_sh (48'(div_pipe[i].den) << (adu_pkg::QUOT_BITS - 1 - i)),
      .q      (div_pipe[i+1])
    );
  end

  assign out_valid = div_pipe[adu_pkg::QUOT_BITS].ctl.valid;
  assign deriv_value = div_pipe[adu_pkg::QUOT_BITS].ctl.is_tanh
                     ? 16'(div_pipe[adu_pkg::QUOT_BITS].q)
                     : div_pipe[adu_pkg::QUOT_BITS].ctl.alt;

endmodule
`default_nettype wire

// ----- hdl/adu_exp_step.sv -----
// One pipeline stage of the exponential: multiply by a fractional power when its bit is set.
`timescale 1ns / 1ps
`default_nettype none
module adu_exp_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire adu_pkg::exp_t d,
  input  wire logic [15:0]   e_coef,
  input  wire logic          use_step,
  output adu_pkg::exp_t      q
);

  logic [32:0] prod;
  logic [33:0] rnd;
  adu_pkg::exp_t q_next;

  always_comb begin
    prod = 33'(d.t) * 33'(e_coef);
    rnd = 34'(prod) + 34'd32768;
    q_next = d;
    if (use_step) begin
      q_next.t = rnd[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.ctl.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/adu_div_step.sv -----
// One restoring-division stage: compare, subtract and shift in one quotient bit.
`timescale 1ns / 1ps
`default_nettype none
module adu_div_step (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire adu_pkg::quot_t d,
  input  wire logic [47:0]    den_sh,
  output adu_pkg::quot_t      q
);

  logic ge;
  adu_pkg::quot_t q_next;

  always_comb begin
    ge = (d.rem >= den_sh);
    q_next = d;
    q_next.q = {d.q[11:0], ge};
    if (ge) begin
      q_next.rem = d.rem - den_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.ctl.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire
